// ----- rtl/artdmx_pkg.sv -----
// Shared constants, types and the gamma table of the Art-Net DMX receiver.
package artdmx_pkg;

  localparam int CHANNELS_PER_UNIVERSE = 510;
  localparam int MAX_PACKET_BYTES      = 576;
  localparam int MAX_UNIVERSES         = 32;

  localparam int HEADER_BYTES      = 17;
  localparam int FIRST_CHANNEL_POS = HEADER_BYTES + 1;
  localparam int LAST_CHANNEL_END  = FIRST_CHANNEL_POS + CHANNELS_PER_UNIVERSE;

  // Byte positions of the header fields
  localparam int ID_BYTES       = 7;
  localparam int POS_OPCODE_LO  = 8;
  localparam int POS_OPCODE_HI  = 9;
  localparam int POS_UNIVERSE_LO = 14;
  localparam int POS_UNIVERSE_HI = 15;

  localparam logic [15:0] OPCODE_DMX = 16'h5000;

  localparam int DATA_W  = 8;
  localparam int POS_W   = 11;
  localparam int LEN_W   = 11;
  localparam int UNI_W   = 16;
  localparam int START_W = 15;
  localparam int COUNT_W = 6;
  localparam int ADDR_W  = 14;
  localparam int OFS_W   = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1;
  localparam int CHAN_W  = (CHANNELS_PER_UNIVERSE > 1) ? $clog2(CHANNELS_PER_UNIVERSE) : 1;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(28);

  typedef enum logic {
    REG_BASE_UNIVERSE  = 1'b0,
    REG_UNIVERSE_COUNT = 1'b1
  } reg_idx_t;

  // One write job handed from the parser to the writer
  typedef struct packed {
    logic              write_enable;
    logic              frame_done;
    logic [OFS_W-1:0]  universe_ofs;
    logic [CHAN_W-1:0] channel;
    logic [DATA_W-1:0] data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [7:0] ART_ID [ID_BYTES] = '{
    8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74
  };

  localparam logic [7:0] GAMMA_LUT [256] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,
    8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd4,
    8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,
    8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,   8'd8,
    8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,  8'd10,
    8'd10,  8'd10,  8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd13,
    8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd15,  8'd16,
    8'd16,  8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd19,
    8'd20,  8'd20,  8'd21,  8'd22,  8'd22,  8'd23,  8'd23,  8'd24,
    8'd24,  8'd25,  8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd28,
    8'd29,  8'd30,  8'd30,  8'd31,  8'd32,  8'd32,  8'd33,  8'd34,
    8'd34,  8'd35,  8'd36,  8'd37,  8'd37,  8'd38,  8'd39,  8'd40,
    8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd44,  8'd45,  8'd46,
    8'd47,  8'd48,  8'd49,  8'd50,  8'd51,  8'd51,  8'd52,  8'd53,
    8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,
    8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd69,  8'd70,
    8'd71,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,  8'd79,
    8'd80,  8'd81,  8'd83,  8'd84,  8'd85,  8'd86,  8'd88,  8'd89,
    8'd90,  8'd92,  8'd93,  8'd94,  8'd96,  8'd97,  8'd98,  8'd100,
    8'd101, 8'd103, 8'd104, 8'd106, 8'd107, 8'd109, 8'd110, 8'd112,
    8'd113, 8'd115, 8'd116, 8'd118, 8'd119, 8'd121, 8'd122, 8'd124,
    8'd126, 8'd127, 8'd129, 8'd131, 8'd132, 8'd134, 8'd136, 8'd137,
    8'd139, 8'd141, 8'd143, 8'd144, 8'd146, 8'd148, 8'd150, 8'd152,
    8'd153, 8'd155, 8'd157, 8'd159, 8'd161, 8'd163, 8'd165, 8'd167,
    8'd169, 8'd171, 8'd173, 8'd175, 8'd177, 8'd179, 8'd181, 8'd183,
    8'd185, 8'd187, 8'd189, 8'd191, 8'd193, 8'd196, 8'd198, 8'd200
  };

endpackage

// ----- rtl/artdmx_channel_receiver_top.sv -----
// Top level of the Art-Net DMX channel receiver: registers, parser, queue and writer.
//
//   channel  direction  handshake          payload
//   in_      sink       in_valid/in_stall  data_byte, packet_length, end_of_packet
//   out_     source     out_valid/out_stall write_enable, channel_address, channel_value,
//                                          frame_done
//   cfg      APB slave  psel/penable/pready base_universe (0x0), universe_count (0x4)
//
// One payload byte is taken per cycle while the queue is not full; a result passes from
// the parser into a four-entry queue and then into the writer's result register.
// The input stalls only while the queue is full; the queue absorbs output stalls.
// Reset is synchronous, active low, and clears parser state and queue pointers.
module artnet_dmx_channel_receiver
  import artdmx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     in_data_byte,
  input  logic [LEN_W-1:0]      in_packet_length,
  input  logic                  in_end_of_packet,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_write_enable,
  output logic [ADDR_W-1:0]     out_channel_address,
  output logic [DATA_W-1:0]     out_channel_value,
  output logic                  out_frame_done,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [START_W-1:0] base_universe_r;
  logic [COUNT_W-1:0] universe_count_r;
  logic               cfg_write;
  reg_idx_t           cfg_idx;

  q_status_t q_status;
  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head_job;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_universe_r  <= '0;
      universe_count_r <= COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_BASE_UNIVERSE:  base_universe_r  <= pwdata[START_W-1:0];
        REG_UNIVERSE_COUNT: universe_count_r <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BASE_UNIVERSE:  prdata = CFG_DATA_W'(base_universe_r);
      REG_UNIVERSE_COUNT: prdata = CFG_DATA_W'(universe_count_r);
      default:            prdata = '0;
    endcase
  end

  artdmx_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_packet_length (in_packet_length),
    .in_end_of_packet (in_end_of_packet),
    .base_universe    (base_universe_r),
    .universe_count   (universe_count_r),
    .q_status         (q_status),
    .push             (push),
    .job              (push_job)
  );

  artdmx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  artdmx_writer u_writer (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_status            (q_status),
    .head_job            (head_job),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_write_enable    (out_write_enable),
    .out_channel_address (out_channel_address),
    .out_channel_value   (out_channel_value),
    .out_frame_done      (out_frame_done)
  );

  // Every result carries a write or a frame end
  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_enable || out_frame_done))
    else $error("empty result transfer");

  // A frame end without a write carries zero address and value
  a_idle_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |->
      (out_channel_address == '0 && out_channel_value == '0))
    else $error("non-write result carries payload");

  // Queue cannot be full and empty at once
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty together");

  // A full queue stays full until the writer takes a job
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_status.full && !pop) |=> q_status.full)
    else $error("queue left full state without a pop");

endmodule

// ----- rtl/artdmx_parser.sv -----
// Front end: tracks the packet header and classifies each payload byte into a write job.
module artdmx_parser
  import artdmx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DATA_W-1:0]  in_data_byte,
  input  logic [LEN_W-1:0]   in_packet_length,
  input  logic               in_end_of_packet,
  input  logic [START_W-1:0] base_universe,
  input  logic [COUNT_W-1:0] universe_count,
  input  q_status_t          q_status,
  output logic               push,
  output job_t               job
);

  logic [POS_W-1:0] byte_position_r, byte_position_nxt;
  logic             header_ok_r, header_ok_nxt;
  logic [7:0]       opcode_low_r, opcode_low_nxt;
  logic             is_dmx_r, is_dmx_nxt;
  logic [7:0]       universe_low_r, universe_low_nxt;
  logic [UNI_W-1:0] universe_number_r, universe_number_nxt;

  logic               take;
  logic [UNI_W-1:0]   uni_cur;
  logic [COUNT_W-1:0] count_eff;
  logic [UNI_W:0]     diff;
  logic               in_window;
  logic               is_last;
  logic               len_ok;
  logic               accepted;
  logic               we;
  logic               fd;
  logic [POS_W-1:0]   chan_full;

  assign in_stall = q_status.full;
  assign take     = in_valid && !q_status.full;

  always_comb begin
    byte_position_nxt   = byte_position_r;
    header_ok_nxt       = header_ok_r;
    opcode_low_nxt      = opcode_low_r;
    is_dmx_nxt          = is_dmx_r;
    universe_low_nxt    = universe_low_r;
    universe_number_nxt = universe_number_r;

    if (byte_position_r == '0) begin
      header_ok_nxt = (in_data_byte == ART_ID[0]);
      is_dmx_nxt    = 1'b0;
    end else if (byte_position_r < POS_W'(ID_BYTES)) begin
      if (in_data_byte != ART_ID[byte_position_r[2:0]]) begin
        header_ok_nxt = 1'b0;
      end
    end else if (byte_position_r == POS_W'(POS_OPCODE_LO)) begin
      opcode_low_nxt = in_data_byte;
    end else if (byte_position_r == POS_W'(POS_OPCODE_HI)) begin
      is_dmx_nxt = ({in_data_byte, opcode_low_r} == OPCODE_DMX);
    end else if (byte_position_r == POS_W'(POS_UNIVERSE_LO)) begin
      universe_low_nxt = in_data_byte;
    end else if (byte_position_r == POS_W'(POS_UNIVERSE_HI)) begin
      universe_number_nxt = {in_data_byte, universe_low_r};
    end

    if (in_end_of_packet) begin
      byte_position_nxt = '0;
    end else if (byte_position_r != POS_MAX) begin
      byte_position_nxt = byte_position_r + POS_W'(1);
    end
  end

  // The universe high byte is used in the same transfer that carries it
  assign uni_cur = (byte_position_r == POS_W'(POS_UNIVERSE_HI)) ?
                   {in_data_byte, universe_low_r} : universe_number_r;

  assign count_eff = (universe_count > COUNT_W'(MAX_UNIVERSES)) ?
                     COUNT_W'(MAX_UNIVERSES) : universe_count;

  assign diff      = {1'b0, uni_cur} - {2'b00, base_universe};
  assign in_window = (count_eff != '0) && !diff[UNI_W] &&
                     (diff[UNI_W-1:0] < UNI_W'(count_eff));
  assign is_last   = in_window && (diff[UNI_W-1:0] == UNI_W'(count_eff) - UNI_W'(1));

  assign len_ok   = (in_packet_length >= LEN_W'(FIRST_CHANNEL_POS)) &&
                    (in_packet_length <= LEN_W'(MAX_PACKET_BYTES));
  assign accepted = len_ok && header_ok_r && is_dmx_r &&
                    (byte_position_r >= POS_W'(POS_UNIVERSE_HI));

  assign we = accepted && in_window &&
              (byte_position_r >= POS_W'(FIRST_CHANNEL_POS)) &&
              (byte_position_r < POS_W'(LAST_CHANNEL_END)) &&
              (byte_position_r < in_packet_length);
  assign fd = in_end_of_packet && accepted && is_last;

  assign chan_full = byte_position_r - POS_W'(FIRST_CHANNEL_POS);

  assign push = take && (we || fd);

  always_comb begin
    job.write_enable = we;
    job.frame_done   = fd;
    job.universe_ofs = diff[OFS_W-1:0];
    job.channel      = chan_full[CHAN_W-1:0];
    job.data         = in_data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r   <= '0;
      header_ok_r       <= 1'b1;
      opcode_low_r      <= '0;
      is_dmx_r          <= 1'b0;
      universe_low_r    <= '0;
      universe_number_r <= '0;
    end else if (take) begin
      byte_position_r   <= byte_position_nxt;
      header_ok_r       <= header_ok_nxt;
      opcode_low_r      <= opcode_low_nxt;
      is_dmx_r          <= is_dmx_nxt;
      universe_low_r    <= universe_low_nxt;
      universe_number_r <= universe_number_nxt;
    end
  end

endmodule

// ----- rtl/artdmx_queue.sv -----
// Short job queue between the parser and the writer.
module artdmx_queue
  import artdmx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head_job,
  output q_status_t q_status
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_status.full  = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_status.empty = (fill_r == '0);

  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;

  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ----- rtl/artdmx_writer.sv -----
// Back end: forms the frame-store address, applies gamma and holds the result register.
module artdmx_writer
  import artdmx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  q_status_t         q_status,
  input  job_t              head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_write_enable,
  output logic [ADDR_W-1:0] out_channel_address,
  output logic [DATA_W-1:0] out_channel_value,
  output logic              out_frame_done
);

  logic              out_valid_r, out_valid_nxt;
  logic              we_r;
  logic              fd_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;

  // Refill the result register when it is empty or being taken
  assign pop = !q_status.empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    addr_nxt  = '0;
    value_nxt = '0;
    if (head_job.write_enable) begin
      addr_nxt  = ADDR_W'(head_job.universe_ofs) * ADDR_W'(CHANNELS_PER_UNIVERSE)
                + ADDR_W'(head_job.channel);
      value_nxt = GAMMA_LUT[head_job.data];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      we_r    <= head_job.write_enable;
      fd_r    <= head_job.frame_done;
      addr_r  <= addr_nxt;
      value_r <= value_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_write_enable    = we_r;
  assign out_channel_address = addr_r;
  assign out_channel_value   = value_r;
  assign out_frame_done      = fd_r;

endmodule
